[rtl/pfw_pkg.sv]
// Shared types and constants of the ping-pong flash log writer.
package pfw_pkg;

   // Buffer and flash geometry
   localparam int FRAMES_PER_BUFFER = 16;
   localparam int FRAME_BYTES       = 128;
   localparam int PAGE_BYTES        = 256;
   localparam int SECTOR_BYTES      = 4096;
   localparam int ADDRESS_BITS      = 26;

   // Field and state widths
   localparam int SLOT_W    = 4;
   localparam int FCOUNT_W  = 5;
   localparam int LEN_W     = 12;
   localparam int WADDR_W   = ADDRESS_BITS + 1;
   localparam int PAGE_W    = $clog2(PAGE_BYTES);
   localparam int SECTOR_W  = $clog2(SECTOR_BYTES);
   localparam int BCOUNT_W  = 9;
   localparam int OFFSET_W  = 11;
   localparam int DROP_W    = 32;
   localparam int CSR_W     = 27;
   localparam int CSR_IDX_W = 1;

   localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(FRAMES_PER_BUFFER * FRAME_BYTES);
   localparam logic [WADDR_W-1:0] END_RESET = WADDR_W'(67108864);

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_ADDR = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_ADDR   = 1'b1;

   typedef enum logic [1:0] {
      OP_PUSH   = 2'd0,
      OP_TICK   = 2'd1,
      OP_FLUSH  = 2'd2,
      OP_ENABLE = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      KIND_NONE    = 3'd0,
      KIND_STORED  = 3'd1,
      KIND_DROPPED = 3'd2,
      KIND_ERASE   = 3'd3,
      KIND_WRITE   = 3'd4,
      KIND_DONE    = 3'd5,
      KIND_ABANDON = 3'd6
   } kind_type;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'b001,
      PH_START = 3'b010,
      PH_WAIT  = 3'b100
   } phase_type;

   typedef struct packed {
      kind_type                 kind;
      logic                     buffer_select;
      logic [SLOT_W-1:0]        slot_index;
      logic [ADDRESS_BITS-1:0]  flash_address;
      logic [OFFSET_W-1:0]      byte_offset;
      logic [BCOUNT_W-1:0]      byte_count;
      logic [DROP_W-1:0]        dropped_total;
      logic                     last;
   } rsp_type;

   // Results of one item: up to two, first goes out first
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

endpackage

[rtl/pfw_core.sv]
// Logger state and flush sequencer: one item per cycle into up to two results.
module pfw_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  pfw_pkg::opcode_type            opcode,
   input  logic                           enable_value,
   input  logic                           flash_busy,
   input  logic                           write_ready,
   input  logic                           csr_wen,
   input  logic [pfw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pfw_pkg::CSR_W-1:0]      csr_wdata,
   output pfw_pkg::push_type              push
);
   import pfw_pkg::*;

   logic                 logging_ff, logging_in;
   logic                 fill_buf_ff, fill_buf_in;
   logic [FCOUNT_W-1:0]  fill_count_ff, fill_count_in;
   logic                 waiting_ff, waiting_in;
   logic                 flush_buf_ff, flush_buf_in;
   logic [LEN_W-1:0]     flush_len_ff, flush_len_in;
   logic [LEN_W-1:0]     flushed_ff, flushed_in;
   phase_type            phase_ff, phase_in;
   logic [WADDR_W-1:0]   waddr_ff, waddr_in;
   logic [WADDR_W-1:0]   end_ff, end_in;
   logic [DROP_W-1:0]    drop_ff, drop_in;

   // page write sizing, from current state only
   logic [LEN_W-1:0]     remain;
   logic [BCOUNT_W-1:0]  space;
   logic [BCOUNT_W-1:0]  wr_count;
   logic [WADDR_W:0]     wr_end;
   logic                 over_end;
   logic                 sector_start;

   // scratch for the comb block
   logic                 full;
   logic                 start_go;
   logic                 fb1, wt1;
   logic [FCOUNT_W-1:0]  fc1, fc2;
   rsp_type              r0, r1, base;
   logic [1:0]           n;

   assign remain   = (flush_len_ff > flushed_ff) ? flush_len_ff - flushed_ff : '0;
   assign space    = BCOUNT_W'(PAGE_BYTES) - BCOUNT_W'(waddr_ff[PAGE_W-1:0]);
   assign wr_count = (remain > LEN_W'(space)) ? space : BCOUNT_W'(remain);
   assign wr_end   = {1'b0, waddr_ff} + (WADDR_W+1)'(wr_count);
   assign over_end = wr_end > {1'b0, end_ff};
   assign sector_start = (waddr_ff[SECTOR_W-1:0] == '0);
   assign full     = fill_count_ff >= FCOUNT_W'(FRAMES_PER_BUFFER);

   always_comb begin
      logging_in    = logging_ff;
      fill_buf_in   = fill_buf_ff;
      fill_count_in = fill_count_ff;
      waiting_in    = waiting_ff;
      flush_buf_in  = flush_buf_ff;
      flush_len_in  = flush_len_ff;
      flushed_in    = flushed_ff;
      phase_in      = phase_ff;
      waddr_in      = waddr_ff;
      end_in        = end_ff;
      drop_in       = drop_ff;
      start_go      = 1'b0;
      fb1           = fill_buf_ff;
      wt1           = waiting_ff;
      fc1           = fill_count_ff;
      fc2           = fill_count_ff;
      n             = 2'd0;
      base          = '0;
      base.kind     = KIND_NONE;
      base.dropped_total = drop_ff;
      r0            = base;
      r1            = base;

      if (accept) begin
         unique case (opcode)
            OP_PUSH: begin
               if (logging_ff) begin
                  if (full && waiting_ff) begin
                     drop_in          = drop_ff + 1'b1;
                     r0.kind          = KIND_DROPPED;
                     r0.dropped_total = drop_in;
                     n                = 2'd1;
                  end else begin
                     if (full) begin
                        flush_buf_in = fill_buf_ff;
                        flush_len_in = FULL_LEN;
                        wt1          = 1'b1;
                        fb1          = ~fill_buf_ff;
                        fc1          = '0;
                     end
                     r0.kind          = KIND_STORED;
                     r0.buffer_select = fb1;
                     r0.slot_index    = fc1[SLOT_W-1:0];
                     n                = 2'd1;
                     fc2              = fc1 + 1'b1;
                     if (fc2 >= FCOUNT_W'(FRAMES_PER_BUFFER) && !wt1) begin
                        flush_buf_in = fb1;
                        flush_len_in = FULL_LEN;
                        wt1          = 1'b1;
                        fb1          = ~fb1;
                        fc2          = '0;
                     end
                     fill_buf_in   = fb1;
                     fill_count_in = fc2;
                     waiting_in    = wt1;
                  end
               end
            end
            OP_TICK: begin
               unique case (phase_ff)
                  PH_START: start_go = 1'b1;
                  PH_WAIT: begin
                     if (!flash_busy) begin
                        if (flushed_ff < flush_len_ff) begin
                           phase_in = PH_START;
                           start_go = 1'b1;
                        end else begin
                           waiting_in       = 1'b0;
                           phase_in         = PH_IDLE;
                           r0.kind          = KIND_DONE;
                           r0.buffer_select = flush_buf_ff;
                           n                = 2'd1;
                        end
                     end
                  end
                  default: begin
                     phase_in = PH_IDLE;
                     if (waiting_ff) begin
                        flushed_in = '0;
                        phase_in   = PH_START;
                     end
                  end
               endcase
               if (start_go) begin
                  priority if (remain == '0) begin
                     waiting_in       = 1'b0;
                     phase_in         = PH_IDLE;
                     r0.kind          = KIND_DONE;
                     r0.buffer_select = flush_buf_ff;
                     n                = 2'd1;
                  end else if (over_end) begin
                     waiting_in       = 1'b0;
                     phase_in         = PH_IDLE;
                     r0.kind          = KIND_ABANDON;
                     r0.buffer_select = flush_buf_ff;
                     r0.flash_address = waddr_ff[ADDRESS_BITS-1:0];
                     n                = 2'd1;
                  end else begin
                     r1.kind          = KIND_WRITE;
                     r1.buffer_select = flush_buf_ff;
                     r1.flash_address = waddr_ff[ADDRESS_BITS-1:0];
                     r1.byte_offset   = flushed_ff[OFFSET_W-1:0];
                     r1.byte_count    = wr_count;
                     if (sector_start) begin
                        r0.kind          = KIND_ERASE;
                        r0.buffer_select = flush_buf_ff;
                        r0.flash_address = waddr_ff[ADDRESS_BITS-1:0];
                        n                = 2'd1;
                     end
                     if (write_ready) begin
                        if (sector_start) begin
                           n = 2'd2;
                        end else begin
                           r0 = r1;
                           n  = 2'd1;
                        end
                        waddr_in   = wr_end[WADDR_W-1:0];
                        flushed_in = flushed_ff + LEN_W'(wr_count);
                        phase_in   = PH_WAIT;
                     end
                  end
               end
            end
            OP_FLUSH: begin
               if (fill_count_ff != '0 && !waiting_ff) begin
                  flush_buf_in  = fill_buf_ff;
                  flush_len_in  = LEN_W'(fill_count_ff) * LEN_W'(FRAME_BYTES);
                  waiting_in    = 1'b1;
                  fill_buf_in   = ~fill_buf_ff;
                  fill_count_in = '0;
               end
            end
            OP_ENABLE: begin
               logging_in = enable_value;
               if (enable_value) begin
                  fill_count_in = '0;
                  waiting_in    = 1'b0;
               end
            end
            default: ;
         endcase
      end

      if (csr_wen) begin
         unique case (csr_index)
            CSR_START_ADDR: waddr_in = WADDR_W'(csr_wdata[ADDRESS_BITS-1:0]);
            CSR_END_ADDR:   end_in   = csr_wdata[WADDR_W-1:0];
            default: ;
         endcase
      end

      r0.last     = (n == 2'd1);
      r1.last     = (n == 2'd2);
      push.count  = n;
      push.first  = r0;
      push.second = r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         logging_ff    <= 1'b0;
         fill_buf_ff   <= 1'b0;
         fill_count_ff <= '0;
         waiting_ff    <= 1'b0;
         flush_buf_ff  <= 1'b0;
         flush_len_ff  <= '0;
         flushed_ff    <= '0;
         phase_ff      <= PH_IDLE;
         waddr_ff      <= '0;
         end_ff        <= END_RESET;
         drop_ff       <= '0;
      end else begin
         logging_ff    <= logging_in;
         fill_buf_ff   <= fill_buf_in;
         fill_count_ff <= fill_count_in;
         waiting_ff    <= waiting_in;
         flush_buf_ff  <= flush_buf_in;
         flush_len_ff  <= flush_len_in;
         flushed_ff    <= flushed_in;
         phase_ff      <= phase_in;
         waddr_ff      <= waddr_in;
         end_ff        <= end_in;
         drop_ff       <= drop_in;
      end
   end

   // waiting on the flash only after a nonempty page went out
   a_wait_has_bytes: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_WAIT |-> flushed_ff != '0)
      else $error("wait phase with nothing flushed");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= FCOUNT_W'(FRAMES_PER_BUFFER))
      else $error("fill count past buffer size");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> push.first.kind == KIND_ERASE && push.second.kind == KIND_WRITE)
      else $error("two results that are not erase then write");

endmodule

[rtl/pfw_rsp_fifo.sv]
// Result queue: takes up to two results per cycle, hands out one per cycle while pop_ready is high.
module pfw_rsp_fifo #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  pfw_pkg::push_type  push,
   input  logic               pop_ready,
   output pfw_pkg::rsp_type   head,
   output logic               head_valid,
   output logic               room_for_two
);
   import pfw_pkg::*;

   localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
   localparam int LVL_W = $clog2(DEPTH + 1);

   rsp_type             mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]    wr_ptr1, wr_ptr2;
   logic [LVL_W-1:0]    level_ff, level_in;
   logic                pop;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign wr_ptr1      = ptr_inc(wr_ptr_ff);
   assign wr_ptr2      = ptr_inc(wr_ptr1);
   assign head         = mem_ff[rd_ptr_ff];
   assign head_valid   = (level_ff != '0);
   assign room_for_two = (level_ff <= LVL_W'(DEPTH - 2));
   assign pop          = head_valid && pop_ready;

   always_comb begin
      unique case (push.count)
         2'd1:    wr_ptr_in = wr_ptr1;
         2'd2:    wr_ptr_in = wr_ptr2;
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      level_in  = level_ff + LVL_W'(push.count) - LVL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr1] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LVL_W'(DEPTH))
      else $error("result queue overflow");

   a_room_on_write: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> LVL_W'(push.count) <= LVL_W'(DEPTH) - level_ff)
      else $error("write into full result queue");

endmodule

[rtl/pingpong_flash_log_writer.sv]
// Top level of the ping-pong flash log writer controller.
//
//  channel | direction | tuser        | tdata (low bit up)                          | tlast
//  --------+-----------+--------------+---------------------------------------------+------
//  req_    | in        | opcode[1:0]  | enable_value, flash_busy, write_ready        | -
//  rsp_    | out       | kind[2:0]    | buffer_select, slot_index, flash_address,    | last
//          |           |              | byte_offset, byte_count, dropped_total       |
//  csr_    | in        | -            | wen, index (0 start, 1 end), wdata[26:0]     | -
//
// An accepted item updates the logger state in the same cycle; its results land in
// the result queue at that edge and show on rsp_ from the next cycle on at the earliest.
// One item per cycle while req_tready is high; a tick that erases and writes yields two
// results on rsp_, so sustained rate is then bound by the single output port of the result queue.
// req_tready drops only when the queue cannot take two more results.
// Synchronous active-high reset clears all state but the result queue storage; end address resets to 2^26.
module pingpong_flash_log_writer #(
   parameter int RSP_DEPTH = 4
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [1:0]                    req_tuser,  // opcode
   input  logic [7:0]                    req_tdata,  // enable_value, flash_busy, write_ready, 0s

   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [2:0]                    rsp_tuser,  // kind
   output logic [87:0]                   rsp_tdata,  // buffer_select, slot_index[3:0],
                                                     // flash_address[25:0], byte_offset[10:0],
                                                     // byte_count[8:0], dropped_total[31:0], 0s
   output logic                          rsp_tlast,  // last result of the item

   input  logic                          csr_wen,
   input  logic [pfw_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pfw_pkg::CSR_W-1:0]     csr_wdata
);
   import pfw_pkg::*;

   localparam int RSP_BITS = 1 + SLOT_W + ADDRESS_BITS + OFFSET_W + BCOUNT_W + DROP_W;

   logic       accept;
   push_type   push;
   rsp_type    head;
   logic       room_for_two;

   assign accept = req_tvalid && req_tready;

   // Item processing: registered state update and combinational result building
   pfw_core u_core (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .opcode       (opcode_type'(req_tuser)),
      .enable_value (req_tdata[0]),
      .flash_busy   (req_tdata[1]),
      .write_ready  (req_tdata[2]),
      .csr_wen      (csr_wen),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .push         (push)
   );

   // Result queue decouples the output side from item acceptance
   pfw_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .pop_ready    (rsp_tready),
      .head         (head),
      .head_valid   (rsp_tvalid),
      .room_for_two (room_for_two)
   );

   assign req_tready = room_for_two;

   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;
   assign rsp_tdata = {(88 - RSP_BITS)'(0), head.dropped_total, head.byte_count,
                       head.byte_offset, head.flash_address, head.slot_index,
                       head.buffer_select};

endmodule

[test/testbench.sv]
// Self-checking testbench of the ping-pong flash log writer controller.
module testbench;
   import pfw_pkg::*;

   // Tracks the logger and flusher state, and queues the results each accepted item must cause.
   class log_writer_scoreboard;
      logic [ADDRESS_BITS-1:0] start_addr;
      logic [WADDR_W-1:0]      end_addr;
      bit                      logging_on;
      bit                      fill_buf;
      logic [FCOUNT_W-1:0]     fill_cnt;
      bit                      flush_queued;
      bit                      flush_buf;
      logic [LEN_W-1:0]        flush_len;
      logic [LEN_W-1:0]        flushed;
      phase_type               phase;
      logic [WADDR_W-1:0]      wr_addr;
      logic [DROP_W-1:0]       drop_cnt;
      rsp_type                 expected_rsps[$];
      int                      errors;
      int                      items;
      int                      kind_seen[8];

      function new();
         start_addr    = '0;
         end_addr      = END_RESET;
         logging_on    = 1'b0;
         fill_buf      = 1'b0;
         fill_cnt      = '0;
         flush_queued  = 1'b0;
         flush_buf     = 1'b0;
         flush_len     = '0;
         flushed       = '0;
         phase         = PH_IDLE;
         wr_addr       = '0;
         drop_cnt      = '0;
         errors        = 0;
         items         = 0;
         foreach (kind_seen[i]) kind_seen[i] = 0;
      endfunction

      function int pending();
         return expected_rsps.size();
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] value);
         if (idx == CSR_START_ADDR) begin
            start_addr = value[ADDRESS_BITS-1:0];
            wr_addr    = WADDR_W'(start_addr);
         end else begin
            end_addr = value[WADDR_W-1:0];
         end
      endfunction

      function void add_result(kind_type k, bit buf_sel, logic [SLOT_W-1:0] slot,
                               logic [WADDR_W-1:0] addr, logic [OFFSET_W-1:0] offset,
                               logic [BCOUNT_W-1:0] bytes);
         rsp_type r;
         r.kind          = k;
         r.buffer_select = buf_sel;
         r.slot_index    = slot;
         r.flash_address = addr[ADDRESS_BITS-1:0];
         r.byte_offset   = offset;
         r.byte_count    = bytes;
         r.dropped_total = drop_cnt;
         r.last          = 1'b0;
         expected_rsps.push_back(r);
      endfunction

      // Fill buffer goes to the flusher; filling moves to the other buffer
      function void hand_over(logic [LEN_W-1:0] len);
         flush_buf     = fill_buf;
         flush_len     = len;
         flush_queued  = 1'b1;
         fill_buf      = ~fill_buf;
         fill_cnt      = '0;
      endfunction

      function void finish_flush(kind_type k, logic [WADDR_W-1:0] addr);
         flush_queued  = 1'b0;
         phase         = PH_IDLE;
         add_result(k, flush_buf, '0, addr, '0, '0);
      endfunction

      // One write attempt: page-bounded, erase first on a sector start
      function void start_write(bit ready);
         logic [LEN_W-1:0]   remain;
         logic [PAGE_W:0]    space;
         logic [WADDR_W:0]   reach;
         remain = (flushed < flush_len) ? flush_len - flushed : '0;
         space  = (PAGE_W+1)'(PAGE_BYTES) - (PAGE_W+1)'(wr_addr[PAGE_W-1:0]);
         if (remain == 0) begin
            finish_flush(KIND_DONE, '0);
            return;
         end
         if (remain > space) remain = LEN_W'(space);
         reach = {1'b0, wr_addr} + (WADDR_W+1)'(remain);
         if (reach > {1'b0, end_addr}) begin
            finish_flush(KIND_ABANDON, wr_addr);
            return;
         end
         if (wr_addr[SECTOR_W-1:0] == 0)
            add_result(KIND_ERASE, flush_buf, '0, wr_addr, '0, '0);
         if (ready) begin
            add_result(KIND_WRITE, flush_buf, '0, wr_addr, OFFSET_W'(flushed),
                       BCOUNT_W'(remain));
            wr_addr = wr_addr + WADDR_W'(remain);
            flushed = flushed + remain;
            phase   = PH_WAIT;
         end
      endfunction

      function void note_item(opcode_type op, bit en, bit busy, bit ready);
         int start_size;
         start_size = expected_rsps.size();
         items++;
         case (op)
            OP_PUSH: begin
               if (logging_on) begin
                  if (fill_cnt >= FRAMES_PER_BUFFER && flush_queued) begin
                     drop_cnt = drop_cnt + 1'b1;
                     add_result(KIND_DROPPED, 1'b0, '0, '0, '0, '0);
                  end else begin
                     if (fill_cnt >= FRAMES_PER_BUFFER)
                        hand_over(LEN_W'(FRAMES_PER_BUFFER * FRAME_BYTES));
                     add_result(KIND_STORED, fill_buf, fill_cnt[SLOT_W-1:0], '0, '0, '0);
                     fill_cnt = fill_cnt + 1'b1;
                     if (fill_cnt >= FRAMES_PER_BUFFER && !flush_queued)
                        hand_over(LEN_W'(FRAMES_PER_BUFFER * FRAME_BYTES));
                  end
               end
            end
            OP_TICK: begin
               case (phase)
                  PH_START: start_write(ready);
                  PH_WAIT: begin
                     if (!busy) begin
                        if (flushed < flush_len) begin
                           phase = PH_START;
                           start_write(ready);
                        end else begin
                           finish_flush(KIND_DONE, '0);
                        end
                     end
                  end
                  default: begin
                     phase = PH_IDLE;
                     if (flush_queued) begin
                        flushed = '0;
                        phase   = PH_START;
                     end
                  end
               endcase
            end
            OP_FLUSH: begin
               if (fill_cnt > 0 && !flush_queued)
                  hand_over(LEN_W'(fill_cnt * FRAME_BYTES));
            end
            default: begin
               logging_on = en;
               if (en) begin
                  fill_cnt      = '0;
                  flush_queued  = 1'b0;
               end
            end
         endcase
         if (expected_rsps.size() > start_size)
            expected_rsps[expected_rsps.size()-1].last = 1'b1;
      endfunction

      function void compare_field(string name, longint unsigned want, longint unsigned got);
         if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_rsps.size() == 0) begin
            $error("unexpected result: kind %0d addr %0h", got.kind, got.flash_address);
            errors++;
            return;
         end
         want = expected_rsps.pop_front();
         kind_seen[int'(want.kind)]++;
         compare_field("kind", want.kind, got.kind);
         compare_field("buffer_select", want.buffer_select, got.buffer_select);
         compare_field("slot_index", want.slot_index, got.slot_index);
         compare_field("flash_address", want.flash_address, got.flash_address);
         compare_field("byte_offset", want.byte_offset, got.byte_offset);
         compare_field("byte_count", want.byte_count, got.byte_count);
         compare_field("dropped_total", want.dropped_total, got.dropped_total);
         compare_field("last", want.last, got.last);
      endfunction
   endclass

   localparam int RANDOM_PHASES   = 6;
   localparam int ITEMS_PER_PHASE = 72;
   localparam int HOLD_CYCLES     = 60;   // long receiver stall to back up the result queue
   localparam int SETTLE_CYCLES   = 4;    // margin after the last expected result is back

   logic                 clock;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [1:0]           req_tuser  = '0;
   logic [7:0]           req_tdata  = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [2:0]           rsp_tuser;
   logic [87:0]          rsp_tdata;
   logic                 rsp_tlast;
   logic                 csr_wen    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [CSR_W-1:0]     csr_wdata  = '0;

   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int hold_seq     = 0;   // bumped by the stimulus to request a receiver hold-off
   int hold_seen    = 0;
   int hold_left    = 0;

   log_writer_scoreboard sb = new();

   pingpong_flash_log_writer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #4000000;
      $display("TB_ERROR");
      $finish;
   end

   // Result side: sample at the edge, then pick next cycle's tready.
   // A pending hold-off request wins over the random stall pattern.
   always @(posedge clock) begin : rsp_side
      rsp_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind          = kind_type'(rsp_tuser);
         got.buffer_select = rsp_tdata[0];
         got.slot_index    = rsp_tdata[4:1];
         got.flash_address = rsp_tdata[30:5];
         got.byte_offset   = rsp_tdata[41:31];
         got.byte_count    = rsp_tdata[50:42];
         got.dropped_total = rsp_tdata[82:51];
         got.last          = rsp_tlast;
         sb.check_result(got);
      end
      if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_seq != hold_seen) begin
         hold_seen  <= hold_seq;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Offer one item, with random idle cycles first; returns at the accepting edge
   task automatic send_item(opcode_type op, bit en, bit busy, bit ready);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {5'b0, ready, busy, en};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_item(op, en, busy, ready);
   endtask

   // Mostly pushes and ticks so buffers fill and flushes run through every page
   task automatic send_random_item();
      int         pick;
      opcode_type op;
      bit         en;
      pick = $urandom_range(99);
      op   = (pick < 45) ? OP_PUSH : (pick < 85) ? OP_TICK : (pick < 92) ? OP_FLUSH : OP_ENABLE;
      en   = (op == OP_ENABLE) ? ($urandom_range(99) < 80) : 1'($urandom_range(1));
      send_item(op, en, $urandom_range(99) < 30, $urandom_range(99) < 70);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] value);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen   <= 1'b0;
      sb.write_register(idx, value);
   endtask

   // Stop offering and wait until every expected result is back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Address window of each random pass: long runs, top of flash, tight windows
   task automatic set_window(int pass);
      longint unsigned base;
      longint unsigned limit;
      case (pass)
         0: begin base = {$urandom_range(255), 12'b0}; limit = 64'd67108864; end
         1: begin base = 64'd67108863; limit = 64'd67108864; end
         2: begin
            base  = $urandom() & 32'h03FF_FFFF;
            limit = base + $urandom_range(12000);
         end
         3: begin base = 0; limit = 0; end
         4: begin base = 64'd67108864 - 64'd8192; limit = 64'd67108864; end
         default: begin
            base  = {$urandom_range(262143), 8'b0};
            limit = base + $urandom_range(20000, 2000);
         end
      endcase
      if (limit > 64'd67108864) limit = 64'd67108864;
      write_register(CSR_START_ADDR, CSR_W'(base));
      write_register(CSR_END_ADDR, CSR_W'(limit));
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed pass at the reset window
      req_idle_pct = 22;
      rsp_idle_pct <= 45;
      write_register(CSR_START_ADDR, '0);
      write_register(CSR_END_ADDR, CSR_W'(67108864));
      send_item(OP_PUSH, 1'b0, 1'b0, 1'b0);     // logging off: ignored
      send_item(OP_FLUSH, 1'b0, 1'b0, 1'b0);    // nothing buffered: ignored
      send_item(OP_TICK, 1'b0, 1'b0, 1'b1);     // idle, no flush waiting
      send_item(OP_ENABLE, 1'b1, 1'b0, 1'b0);
      hold_seq <= hold_seq + 1;                 // receiver stalls while pushes pile up
      repeat (6) send_item(OP_PUSH, 1'b0, 1'b1, 1'b1);
      send_item(OP_ENABLE, 1'b0, 1'b1, 1'b0);
      send_item(OP_PUSH, 1'b1, 1'b0, 1'b1);     // off again: ignored
      send_item(OP_FLUSH, 1'b1, 1'b1, 1'b1);    // partial buffer handed over while off
      send_item(OP_FLUSH, 1'b0, 1'b0, 1'b0);    // flush already waiting: ignored
      send_item(OP_TICK, 1'b0, 1'b0, 1'b0);     // idle -> start
      send_item(OP_TICK, 1'b0, 1'b0, 1'b0);     // sector start, not ready: erase only
      send_item(OP_TICK, 1'b0, 1'b0, 1'b1);     // erase again, then page write
      send_item(OP_TICK, 1'b1, 1'b1, 1'b1);     // flash busy: wait
      send_item(OP_TICK, 1'b0, 1'b0, 1'b0);     // mid-sector, not ready: nothing
      send_item(OP_TICK, 1'b1, 1'b0, 1'b1);     // second page
      send_item(OP_TICK, 1'b0, 1'b0, 1'b1);     // third page, last of the buffer
      send_item(OP_TICK, 1'b0, 1'b0, 1'b1);     // nothing left: flush done
      send_item(OP_ENABLE, 1'b1, 1'b1, 1'b1);
      drain();

      // Random passes; idling goes receiver-heavy, sender-heavy, then none
      for (int pass = 0; pass < RANDOM_PHASES; pass++) begin
         case (pass / 2)
            0:       begin req_idle_pct = 22; rsp_idle_pct <= 45; end
            1:       begin req_idle_pct = 45; rsp_idle_pct <= 22; end
            default: begin req_idle_pct = 0;  rsp_idle_pct <= 0;  end
         endcase
         set_window(pass);
         send_item(OP_ENABLE, 1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)));
         repeat (ITEMS_PER_PHASE) send_random_item();
         drain();
      end

      $display("Ran %0d items through %0d address windows, with and without idling.",
               sb.items, RANDOM_PHASES + 1);
      $display("Seen: %0d stored, %0d dropped, %0d erases, %0d page writes, %0d done, %0d abandoned",
               sb.kind_seen[KIND_STORED], sb.kind_seen[KIND_DROPPED], sb.kind_seen[KIND_ERASE],
               sb.kind_seen[KIND_WRITE], sb.kind_seen[KIND_DONE], sb.kind_seen[KIND_ABANDON]);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
